// ----- hdl/tse_pkg.sv -----
// Package: shared types and constants, including the sine polynomial coefficients, for the series evaluator.
package tse_pkg;

	localparam int MAX_COEFFS = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int COEF_W = 24;
	localparam int ACC_W = 48;

	localparam logic [31:0] TPU_RESET = 32'h0100_0000;
	localparam logic [16:0] SIN_A = 17'd51472;
	localparam logic [16:0] SIN_B = 17'd21024;
	localparam logic [16:0] SIN_C = 17'd2320;
	localparam logic signed [17:0] Q15_ONE = 18'sd32768;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	localparam logic [0:0] REG_TPU = 1'd0;
	localparam logic [0:0] REG_NUM = 1'd1;

	typedef struct packed {
		logic req_type;
		logic [5:0] coef_index;
		logic signed [23:0] coef_re;
		logic signed [23:0] coef_im;
		logic signed [31:0] sample_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value_re;
		logic signed [31:0] value_im;
		logic saturated;
	} out_item_t;

	// control from sequencer to MAC datapath
	typedef struct packed {
		logic clear;
		logic mac_en;
	} mac_ctl_t;

endpackage

// ----- hdl/tse_sine.sv -----
// Sine unit: sequential polynomial evaluation, one multiply per cycle.
module tse_sine (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [31:0] phase,
	output logic done,
	output logic signed [17:0] result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_X2 = 3'd1;
	localparam logic [2:0] ST_T1 = 3'd2;
	localparam logic [2:0] ST_T2 = 3'd3;
	localparam logic [2:0] ST_S = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [16:0] x_q;
	logic [16:0] t_q;
	logic [16:0] x2_q;
	logic neg_q;
	logic [16:0] mul_a;
	logic [16:0] mul_b;
	logic [33:0] prod;
	logic [14:0] r;

	assign r = phase[29:15];

	// shared multiplier operand select
	always_comb begin
		mul_a = x_q;
		mul_b = t_q;
		case (state_q)
			ST_X2: mul_b = x_q;
			ST_T1: begin
				mul_a = t_q;
				mul_b = tse_pkg::SIN_C;
			end
			ST_T2: mul_a = x2_q;
			default: mul_b = t_q;
		endcase
	end
	assign prod = mul_a * mul_b;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_X2;
				ST_X2: state_q <= ST_T1;
				ST_T1: state_q <= ST_T2;
				ST_T2: state_q <= ST_S;
				ST_S: state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: t_q holds x2, then t1, then t2 (x2 kept in a second slot)
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (start) begin
				x_q <= phase[30] ? (17'd32768 - {2'b00, r}) : {2'b00, r};
				neg_q <= phase[31];
			end
			ST_X2: begin
				x2_q <= 17'(prod >> 15);
				t_q <= 17'(prod >> 15);
			end
			ST_T1: t_q <= tse_pkg::SIN_B - 17'(prod >> 15);
			ST_T2: t_q <= tse_pkg::SIN_A - 17'(prod >> 15);
			ST_S: begin
				result <= neg_q ? -$signed({1'b0, 17'(prod >> 15)})
					: $signed({1'b0, 17'(prod >> 15)});
			end
			default: ;
		endcase
	end

	assign done = (state_q == ST_DONE);

	ap_done_after_s: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_S |=> done) else $error("sine done missing");
	ap_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result <= 18'sd32768 && result >= -18'sd32768))
		else $error("sine out of range");
	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && state_q == ST_IDLE |=> state_q == ST_X2) else $error("sine start lost");

endmodule

// ----- hdl/tse_mac.sv -----
// Complex-by-real accumulator with final floor shift and saturation.
module tse_mac (
	input  logic clk,
	input  logic arst_n,
	input  tse_pkg::mac_ctl_t ctl,
	input  logic signed [23:0] coef_re,
	input  logic signed [23:0] coef_im,
	input  logic signed [17:0] basis,
	output tse_pkg::out_item_t result
);

	logic signed [tse_pkg::ACC_W-1:0] sum_re_q;
	logic signed [tse_pkg::ACC_W-1:0] sum_im_q;
	logic signed [41:0] p_re;
	logic signed [41:0] p_im;
	logic signed [32:0] sh_re;
	logic signed [32:0] sh_im;
	logic sat_re;
	logic sat_im;

	function automatic logic signed [tse_pkg::ACC_W-1:0] ACC_EXT(input logic signed [41:0] v);
		return tse_pkg::ACC_W'(v);
	endfunction

	assign p_re = coef_re * basis;
	assign p_im = coef_im * basis;

	// accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_re_q <= '0;
			sum_im_q <= '0;
		end else if (ctl.clear) begin
			sum_re_q <= '0;
			sum_im_q <= '0;
		end else if (ctl.mac_en) begin
			sum_re_q <= sum_re_q + ACC_EXT(p_re);
			sum_im_q <= sum_im_q + ACC_EXT(p_im);
		end
	end

	// floor shift (arithmetic) and clip
	assign sh_re = 33'(sum_re_q >>> 15);
	assign sh_im = 33'(sum_im_q >>> 15);
	assign sat_re = (sum_re_q >>> 15) > 48'sh7FFF_FFFF || (sum_re_q >>> 15) < -48'sh8000_0000;
	assign sat_im = (sum_im_q >>> 15) > 48'sh7FFF_FFFF || (sum_im_q >>> 15) < -48'sh8000_0000;

	always_comb begin
		result.value_re = sat_re ? (sum_re_q[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
			: sh_re[31:0];
		result.value_im = sat_im ? (sum_im_q[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
			: sh_im[31:0];
		result.saturated = sat_re | sat_im;
	end

	ap_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> sum_re_q == 0 && sum_im_q == 0) else $error("clear failed");
	ap_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.clear && ctl.mac_en)) else $error("clear with mac");
	ap_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		!result.saturated |-> 33'(result.value_re) == sh_re) else $error("clip");

endmodule

// ----- hdl/trig_series_evaluator.sv -----
// Top level: coefficient table, phase generation and term sequencer.
// During an evaluate with N terms, in_stall stays high after its transfer through
// the phase step product, term 0, and every later term (the sequencer steps the phase
// on odd terms and starts the sine unit, which runs its four shared-multiplier steps
// and done, then a MAC), and then the result load; with N of 0 the load follows the product.
// The result then waits on the output register, and the next input is taken
// no sooner than the cycle after the result transfer.
// A load completes in its transfer cycle and another item may follow at once.
// in_stall is high while an item is in progress or a result waits on the output
// register. The coefficient table reads as undefined until loaded.
module trig_series_evaluator (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  tse_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output tse_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PROD = 3'd1;
	localparam logic [2:0] S_TERM = 3'd2;
	localparam logic [2:0] S_SIN = 3'd3;
	localparam logic [2:0] S_MAC = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0] state_q;
	logic [31:0] tpu_q;
	logic [6:0] num_q;
	logic [6:0] n_q;
	logic [6:0] i_q;
	logic signed [31:0] t_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [47:0] mem [tse_pkg::MAX_COEFFS];
	logic [47:0] rd_q;
	logic signed [17:0] basis_q;
	logic sin_start;
	logic sin_done;
	logic signed [17:0] sin_val;
	logic [31:0] phase;
	logic signed [64:0] prod_full;
	logic [63:0] acc_sum;
	tse_pkg::mac_ctl_t ctl;
	tse_pkg::out_item_t mac_res;
	logic accept;

	assign in_stall = (state_q != S_IDLE) || out_valid;
	assign accept = in_valid && !in_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= tse_pkg::TPU_RESET;
			num_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tse_pkg::REG_TPU: tpu_q <= cfg_data;
				tse_pkg::REG_NUM: num_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// coefficient table
	always_ff @(posedge clk) begin
		if (accept && in_data.req_type == tse_pkg::REQ_LOAD)
			mem[in_data.coef_index] <= {in_data.coef_re, in_data.coef_im};
		rd_q <= mem[i_q[5:0]];
	end

	assign phase = acc_q[39:8];

	// phase step: signed time by unsigned rate, exact
	assign prod_full = $signed(t_q) * $signed({1'b0, tpu_q});
	assign acc_sum = acc_q + prod_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (accept && in_data.req_type == tse_pkg::REQ_EVAL) state_q <= S_PROD;
				S_PROD: state_q <= (n_q == 0) ? S_OUT : S_TERM;
				S_TERM: state_q <= (i_q == 0) ? S_MAC : S_SIN;
				S_SIN: if (sin_done) state_q <= S_MAC;
				S_MAC: state_q <= (i_q + 7'd1 == n_q) ? S_OUT : S_TERM;
				S_OUT: begin
					state_q <= S_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				t_q <= in_data.sample_time;
				n_q <= (num_q > 7'(tse_pkg::MAX_COEFFS)) ? 7'(tse_pkg::MAX_COEFFS) : num_q;
				i_q <= '0;
				acc_q <= '0;
			end
			S_PROD: prod_q <= prod_full[63:0];
			S_TERM: if (i_q[0]) acc_q <= acc_sum;
			S_SIN: if (sin_done) basis_q <= sin_val;
			S_MAC: i_q <= i_q + 7'd1;
			S_OUT: out_data <= mac_res;
			default: ;
		endcase
		if (state_q == S_TERM && i_q == 0) basis_q <= tse_pkg::Q15_ONE;
	end

	assign sin_start = (state_q == S_TERM) && (i_q != 0);
	assign ctl.clear = (state_q == S_PROD);
	assign ctl.mac_en = (state_q == S_MAC);

	tse_sine u_sine (
		.clk(clk), .arst_n(arst_n), .start(sin_start),
		.phase(i_q[0] ? acc_sum[39:8] : (phase + 32'h4000_0000)),
		.done(sin_done), .result(sin_val)
	);

	tse_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.coef_re(rd_q[47:24]), .coef_im(rd_q[23:0]), .basis(basis_q),
		.result(mac_res)
	);

	ap_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |=> out_valid) else $error("result lost");
	ap_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accept while busy");
	ap_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAC |-> i_q < n_q) else $error("index overrun");

endmodule

// ----- test/testbench.sv -----
// Testbench for the trig series evaluator: directed and random transfers checked against a predictor.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	tse_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	tse_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = tse_pkg::REG_TPU;
	logic [31:0] cfg_data = '0;

	// predictor copy of the block state
	logic signed [23:0] table_re [tse_pkg::MAX_COEFFS];
	logic signed [23:0] table_im [tse_pkg::MAX_COEFFS];
	logic [31:0] tpu_shadow = tse_pkg::TPU_RESET;
	logic [6:0] count_shadow = '0;

	tse_pkg::out_item_t series_expected [$];
	int mismatches = 0;
	int results_seen = 0;
	int loads_sent = 0;
	int evals_sent = 0;
	int cycles = 0;
	int stall_left = 0;

	trig_series_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Q1.15 sine of a 32-bit turn fraction, polynomial per quadrant
	function automatic longint sine_q15(logic [31:0] phase);
		longint unsigned x, x2, t1, t2, s;
		x = phase[30] ? (64'd32768 - phase[29:15]) : phase[29:15];
		x2 = (x * x) >> 15;
		t1 = tse_pkg::SIN_B - ((x2 * tse_pkg::SIN_C) >> 15);
		t2 = tse_pkg::SIN_A - ((x2 * t1) >> 15);
		s = (x * t2) >> 15;
		return phase[31] ? -longint'(s) : longint'(s);
	endfunction

	// series value at one sample time from the shadow table
	function automatic tse_pkg::out_item_t series_value(logic signed [31:0] t);
		logic [63:0] step_phase, phase_acc;
		longint sum_re, sum_im, basis, v_re, v_im;
		int n;
		tse_pkg::out_item_t r;
		step_phase = 64'(longint'(t)) * {32'd0, tpu_shadow};
		phase_acc = '0;
		sum_re = 0;
		sum_im = 0;
		n = (count_shadow > tse_pkg::MAX_COEFFS) ? tse_pkg::MAX_COEFFS : count_shadow;
		for (int i = 0; i < n; i++) begin
			if (i == 0) begin
				basis = 32768;
			end else if (i % 2 == 1) begin
				phase_acc += step_phase;
				basis = sine_q15(phase_acc[39:8]);
			end else begin
				basis = sine_q15(phase_acc[39:8] + 32'h4000_0000);
			end
			sum_re += longint'(table_re[i]) * basis;
			sum_im += longint'(table_im[i]) * basis;
		end
		v_re = sum_re >>> 15;
		v_im = sum_im >>> 15;
		r.saturated = 1'b0;
		if (v_re > 64'sd2147483647 || v_re < -64'sd2147483648) begin
			r.saturated = 1'b1;
			v_re = (v_re > 0) ? 64'sd2147483647 : -64'sd2147483648;
		end
		if (v_im > 64'sd2147483647 || v_im < -64'sd2147483648) begin
			r.saturated = 1'b1;
			v_im = (v_im > 0) ? 64'sd2147483647 : -64'sd2147483648;
		end
		r.value_re = v_re[31:0];
		r.value_im = v_im[31:0];
		return r;
	endfunction

	// one input transfer; gap is the idle time that follows it
	task automatic send_item(tse_pkg::in_item_t item, int gap);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		if (item.req_type == tse_pkg::REQ_LOAD) begin
			table_re[item.coef_index] = item.coef_re;
			table_im[item.coef_index] = item.coef_im;
			loads_sent++;
		end else begin
			series_expected.push_back(series_value(item.sample_time));
			evals_sent++;
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_load(logic [5:0] idx, logic [23:0] re, logic [23:0] im, int gap);
		tse_pkg::in_item_t item;
		item = tse_pkg::in_item_t'(87'({$urandom, $urandom, $urandom}));
		item.req_type = tse_pkg::REQ_LOAD;
		item.coef_index = idx;
		item.coef_re = re;
		item.coef_im = im;
		send_item(item, gap);
	endtask

	task automatic send_eval(logic [31:0] t, int gap);
		tse_pkg::in_item_t item;
		item = tse_pkg::in_item_t'(87'({$urandom, $urandom, $urandom}));
		item.req_type = tse_pkg::REQ_EVAL;
		item.sample_time = t;
		send_item(item, gap);
	endtask

	function automatic int random_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// stop sending and wait until every result is back and the block is quiet
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (series_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register writes go in only once nothing is in flight
	task automatic write_reg(logic [0:0] idx, logic [31:0] value);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == tse_pkg::REG_TPU)
			tpu_shadow = value;
		else
			count_shadow = value[6:0];
	endtask

	task automatic test_zero_count();
		send_eval(32'h7FFF_FFFF, 0);
		send_eval(32'h8000_0000, 2);
		drain();
	endtask

	// fill every entry so later evaluations never read an unwritten one
	task automatic test_table_fill();
		for (int i = 0; i < tse_pkg::MAX_COEFFS; i++) begin
			case (i)
				0: send_load(6'(i), 24'h7F_FFFF, 24'h80_0000, 0);
				1: send_load(6'(i), 24'h80_0000, 24'h7F_FFFF, 0);
				2: send_load(6'(i), 24'h00_0000, 24'hFF_FFFF, 0);
				default: send_load(6'(i), 24'($urandom), 24'($urandom), random_gap());
			endcase
		end
		drain();
	endtask

	task automatic test_directed_eval();
		write_reg(tse_pkg::REG_NUM, 7'd1);
		send_eval(32'h0001_0000, 0);
		write_reg(tse_pkg::REG_NUM, 7'd2);
		send_eval(32'h0000_4000, 0);
		send_eval(32'hFFFF_C000, 0);
		drain();
		write_reg(tse_pkg::REG_NUM, 7'd64);
		send_eval(32'h0000_0000, 0);
		send_eval(32'h7FFF_FFFF, 1);
		send_eval(32'h8000_0000, 0);
		drain();
		// counts above the table size clip to the full table
		write_reg(tse_pkg::REG_NUM, 7'd127);
		write_reg(tse_pkg::REG_TPU, 32'hFFFF_FFFF);
		send_eval(32'h7FFF_FFFF, 0);
		send_eval(32'h8000_0000, 0);
		drain();
		write_reg(tse_pkg::REG_TPU, 32'h0000_0000);
		write_reg(tse_pkg::REG_NUM, 7'd65);
		send_eval(32'h1234_5678, 0);
		drain();
		// all-large coefficients in phase at t=0
		for (int i = 0; i < tse_pkg::MAX_COEFFS; i++)
			send_load(6'(i), 24'h7F_FFFF, 24'h80_0000, 0);
		write_reg(tse_pkg::REG_TPU, tse_pkg::TPU_RESET);
		write_reg(tse_pkg::REG_NUM, 7'd64);
		send_eval(32'h0000_0000, 0);
		drain();
	endtask

	task automatic test_random_phases();
		logic [31:0] tpu;
		logic [6:0] cnt;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: tpu = 32'h0000_0000;
				1: tpu = 32'hFFFF_FFFF;
				2: tpu = tse_pkg::TPU_RESET;
				default: tpu = $urandom;
			endcase
			case (p)
				0: cnt = 7'd0;
				1: cnt = 7'd127;
				2: cnt = 7'd64;
				3: cnt = 7'd3;
				default: cnt = 7'($urandom_range(0, 127));
			endcase
			write_reg(tse_pkg::REG_TPU, tpu);
			write_reg(tse_pkg::REG_NUM, cnt);
			for (int k = 0; k < 64; k++) begin
				if ($urandom_range(0, 99) < 40)
					send_load(6'($urandom), 24'($urandom), 24'($urandom), random_gap());
				else
					send_eval($urandom, random_gap());
			end
			drain();
		end
	endtask

	// result checker
	always @(posedge clk) begin
		tse_pkg::out_item_t exp_item;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (series_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result re=%h im=%h sat=%b",
						out_data.value_re, out_data.value_im, out_data.saturated);
			end else begin
				exp_item = series_expected.pop_front();
				if (out_data.value_re !== exp_item.value_re
						|| out_data.value_im !== exp_item.value_im
						|| out_data.saturated !== exp_item.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected re=%h im=%h sat=%b, got re=%h im=%h sat=%b",
							exp_item.value_re, exp_item.value_im, exp_item.saturated,
							out_data.value_re, out_data.value_im, out_data.saturated);
				end
			end
		end
	end

	// output backpressure: short bursts, a few long ones, quiet stretches between
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 25) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : 0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		for (int i = 0; i < tse_pkg::MAX_COEFFS; i++) begin
			table_re[i] = '0;
			table_im[i] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_zero_count();
		test_table_fill();
		test_directed_eval();
		test_random_phases();
		$display("covered %0d loads and %0d evaluations, %0d results checked, %0d mismatches",
			loads_sent, evals_sent, results_seen, mismatches);
		$display("register settings swept include zero and full-scale rate, counts 0 to 127");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
